/* rtl/core/ptfc_pkg.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ptfc_pkg
// Shared types and constants for the page translation ring cache.
// ----------------------------------------------------------------------------
package ptfc_pkg;

	localparam int FIELD_W          = 20;
	localparam int RING_ENTRIES_DEF = 16;
	localparam int CMD_W            = 2;
	localparam int S_TDATA_W        = 64;
	localparam int M_TDATA_W        = 24;

	typedef enum logic [CMD_W-1:0] {
		CMD_LOOKUP = 2'd0,
		CMD_INSERT = 2'd1,
		CMD_INVAL  = 2'd2,
		CMD_CLEAR  = 2'd3
	} cmd_e;

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_SCAN,
		ST_WAIT
	} state_e;

	typedef struct packed {
		logic capture;
		logic scan_init;
		logic scan_run;
		logic do_insert;
		logic do_clear;
		logic res_load;
		logic out_load_zero;
		logic out_load_res;
	} ctl_t;

	typedef struct packed {
		logic ring_empty;
		logic scan_end;
		logic out_free;
	} sts_t;

endpackage

/* rtl/core/ptfc_ctrl.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ptfc_ctrl
// Controller: accepts transactions, runs the newest-to-oldest ring scan and
// hands the result to the output register.
// ----------------------------------------------------------------------------
module ptfc_ctrl
	import ptfc_pkg::*;
(
	input  logic clk,
	input  logic arst_n,
	input  logic in_valid,
	output logic in_ready,
	input  cmd_e cmd,
	input  sts_t sts,
	output ctl_t ctl
);

	state_e state_q;
	state_e state_d;
	logic   accept;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	assign in_ready = (state_q == ST_IDLE) && sts.out_free;
	assign accept   = in_valid && in_ready;

	always_comb begin
		state_d = state_q;
		ctl     = '0;
		unique case (state_q)
			ST_IDLE: begin
				if (accept) begin
					unique case (cmd)
						CMD_LOOKUP, CMD_INVAL: begin
							if (sts.ring_empty) begin
								ctl.out_load_zero = 1'b1;
							end else begin
								ctl.capture   = 1'b1;
								ctl.scan_init = 1'b1;
								state_d       = ST_SCAN;
							end
						end
						CMD_INSERT: begin
							ctl.do_insert     = 1'b1;
							ctl.out_load_zero = 1'b1;
						end
						CMD_CLEAR: begin
							ctl.do_clear      = 1'b1;
							ctl.out_load_zero = 1'b1;
						end
						default: begin
							ctl.out_load_zero = 1'b1;
						end
					endcase
				end
			end
			ST_SCAN: begin
				ctl.scan_run = 1'b1;
				if (sts.scan_end) begin
					ctl.res_load = 1'b1;
					state_d      = ST_WAIT;
				end
			end
			ST_WAIT: begin
				if (sts.out_free) begin
					ctl.out_load_res = 1'b1;
					state_d          = ST_IDLE;
				end
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase
	end

endmodule

/* rtl/core/ptfc_datapath.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ptfc_datapath
// Ring pointers, entry memory, scan read stage, compare and output register.
// ----------------------------------------------------------------------------
module ptfc_datapath
	import ptfc_pkg::*;
#(
	parameter int RING_ENTRIES = RING_ENTRIES_DEF
) (
	input  logic               clk,
	input  logic               arst_n,
	input  ctl_t               ctl,
	output sts_t               sts,
	input  cmd_e               in_cmd,
	input  logic [FIELD_W-1:0] in_start,
	input  logic [FIELD_W-1:0] in_page,
	input  logic [FIELD_W-1:0] in_frame,
	input  logic               out_ready,
	output logic               out_valid,
	output logic               out_hit,
	output logic [FIELD_W-1:0] out_frame
);

	localparam int IDX_W = $clog2(RING_ENTRIES);
	localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(RING_ENTRIES - 1);

	typedef struct packed {
		logic [FIELD_W-1:0] tag;
		logic [FIELD_W-1:0] page;
		logic [FIELD_W-1:0] frame;
	} entry_t;

	function automatic logic [IDX_W-1:0] ring_next(input logic [IDX_W-1:0] idx);
		return (idx == LAST_IDX) ? '0 : idx + 1'b1;
	endfunction

	function automatic logic [IDX_W-1:0] ring_prev(input logic [IDX_W-1:0] idx);
		return (idx == '0) ? LAST_IDX : idx - 1'b1;
	endfunction

	entry_t             mem [RING_ENTRIES];
	logic               wr_en;
	logic [IDX_W-1:0]   wr_addr;
	entry_t             wr_data;

	logic [IDX_W-1:0]   oldest_q;
	logic [IDX_W-1:0]   next_free_q;
	logic [IDX_W-1:0]   next_free_inc;
	logic [IDX_W-1:0]   scan_ptr_q;
	logic               issue_done_q;
	logic               rd_issue;

	logic               rd_valid_s1;
	logic               rd_last_s1;
	logic [IDX_W-1:0]   rd_addr_s1;
	entry_t             rd_data_s1;

	cmd_e               cmd_q;
	logic [FIELD_W-1:0] start_q;
	logic [FIELD_W-1:0] page_q;

	logic               match;
	logic               res_hit_q;
	logic [FIELD_W-1:0] res_frame_q;
	logic               out_valid_q;
	logic               out_hit_q;
	logic [FIELD_W-1:0] out_frame_q;

	assign next_free_inc = ring_next(next_free_q);
	assign rd_issue      = ctl.scan_run && !issue_done_q && !sts.scan_end;

	assign match = rd_valid_s1 && (rd_data_s1.tag == start_q) &&
	               ((rd_data_s1.page == page_q) || (cmd_q != CMD_LOOKUP));

	assign sts.ring_empty = (oldest_q == next_free_q);
	assign sts.scan_end   = rd_valid_s1 && (match || rd_last_s1);
	assign sts.out_free   = !out_valid_q || out_ready;

	always_comb begin
		wr_en   = 1'b0;
		wr_addr = next_free_q;
		wr_data = '{tag: in_start, page: in_page, frame: in_frame};
		if (ctl.do_insert) begin
			wr_en = 1'b1;
		end else if (ctl.res_load && match && (cmd_q == CMD_INVAL)) begin
			wr_en   = 1'b1;
			wr_addr = rd_addr_s1;
			wr_data = '{tag: '0, page: rd_data_s1.page, frame: rd_data_s1.frame};
		end
	end

	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem[wr_addr] <= wr_data;
		end
		if (rd_issue) begin
			rd_data_s1 <= mem[scan_ptr_q];
			rd_addr_s1 <= scan_ptr_q;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			oldest_q     <= '0;
			next_free_q  <= '0;
			scan_ptr_q   <= '0;
			issue_done_q <= 1'b0;
			rd_valid_s1  <= 1'b0;
			rd_last_s1   <= 1'b0;
			out_valid_q  <= 1'b0;
		end else begin
			if (ctl.do_clear) begin
				oldest_q    <= '0;
				next_free_q <= '0;
			end else if (ctl.do_insert) begin
				next_free_q <= next_free_inc;
				if (next_free_inc == oldest_q) begin
					oldest_q <= ring_next(oldest_q);
				end
			end
			if (ctl.scan_init) begin
				scan_ptr_q   <= ring_prev(next_free_q);
				issue_done_q <= 1'b0;
			end else if (rd_issue) begin
				scan_ptr_q   <= ring_prev(scan_ptr_q);
				issue_done_q <= (scan_ptr_q == oldest_q);
			end
			rd_valid_s1 <= rd_issue;
			if (rd_issue) begin
				rd_last_s1 <= (scan_ptr_q == oldest_q);
			end
			if (ctl.out_load_zero || ctl.out_load_res) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (ctl.capture) begin
			cmd_q   <= in_cmd;
			start_q <= in_start;
			page_q  <= in_page;
		end
		if (ctl.res_load) begin
			res_hit_q   <= match && (cmd_q == CMD_LOOKUP);
			res_frame_q <= (match && (cmd_q == CMD_LOOKUP)) ? rd_data_s1.frame : '0;
		end
		if (ctl.out_load_zero) begin
			out_hit_q   <= 1'b0;
			out_frame_q <= '0;
		end else if (ctl.out_load_res) begin
			out_hit_q   <= res_hit_q;
			out_frame_q <= res_frame_q;
		end
	end

	assign out_valid = out_valid_q;
	assign out_hit   = out_hit_q;
	assign out_frame = out_frame_q;

endmodule

/* rtl/core/page_translation_fifo_cache.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// page_translation_fifo_cache
// Ring-organised translation cache mapping (process start, page) to frame.
//
//   channel  | direction | contents
//   ---------+-----------+-----------------------------------------------
//   s_axis   | in        | tuser: cmd; tdata: start, page, frame
//   m_axis   | out       | tuser: hit; tdata: frame_out
//
// Insert, clear, and lookup or invalidate on an empty ring load an empty
// result straight from idle. Lookup and invalidate read one ring entry per
// cycle through the single memory read port, newest first, stopping at a
// match; at most RING_ENTRIES-1 entries are read.
// Reset clears both pointers at once; entries need no clearing.
// A stalled m_axis holds the result and blocks s_axis until it is taken.
// ----------------------------------------------------------------------------
module page_translation_fifo_cache
	import ptfc_pkg::*;
#(
	parameter int RING_ENTRIES = RING_ENTRIES_DEF
) (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 s_axis_tvalid,
	output logic                 s_axis_tready,
	input  logic [S_TDATA_W-1:0] s_axis_tdata,  // process_start, virtual_page, frame_in, pad
	input  logic [CMD_W-1:0]     s_axis_tuser,  // cmd
	output logic                 m_axis_tvalid,
	input  logic                 m_axis_tready,
	output logic [M_TDATA_W-1:0] m_axis_tdata,  // frame_out, pad
	output logic                 m_axis_tuser   // hit
);

	ctl_t               ctl;
	sts_t               sts;
	logic [FIELD_W-1:0] frame_out;

	ptfc_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (s_axis_tvalid),
		.in_ready (s_axis_tready),
		.cmd      (cmd_e'(s_axis_tuser)),
		.sts      (sts),
		.ctl      (ctl)
	);

	ptfc_datapath #(
		.RING_ENTRIES (RING_ENTRIES)
	) u_datapath (
		.clk       (clk),
		.arst_n    (arst_n),
		.ctl       (ctl),
		.sts       (sts),
		.in_cmd    (cmd_e'(s_axis_tuser)),
		.in_start  (s_axis_tdata[FIELD_W-1:0]),
		.in_page   (s_axis_tdata[2*FIELD_W-1:FIELD_W]),
		.in_frame  (s_axis_tdata[3*FIELD_W-1:2*FIELD_W]),
		.out_ready (m_axis_tready),
		.out_valid (m_axis_tvalid),
		.out_hit   (m_axis_tuser),
		.out_frame (frame_out)
	);

	assign m_axis_tdata = {(M_TDATA_W - FIELD_W)'(0), frame_out};

endmodule

/* rtl/core/ptfc_checker.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ptfc_checker
// Port-level checks for the page translation ring cache.
// ----------------------------------------------------------------------------
module ptfc_checker
	import ptfc_pkg::*;
(
	input logic                 clk,
	input logic                 arst_n,
	input logic                 s_axis_tvalid,
	input logic                 s_axis_tready,
	input logic [CMD_W-1:0]     s_axis_tuser,
	input logic                 m_axis_tvalid,
	input logic                 m_axis_tready,
	input logic [M_TDATA_W-1:0] m_axis_tdata,
	input logic                 m_axis_tuser
);

	logic in_xfer;

	assign in_xfer = s_axis_tvalid && s_axis_tready;

	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid && !m_axis_tready |=>
			m_axis_tvalid && $stable(m_axis_tdata) && $stable(m_axis_tuser))
		else $error("stalled result changed");

	a_no_accept_on_stall: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid && !m_axis_tready |-> !s_axis_tready)
		else $error("transaction accepted while result stalled");

	a_write_result: assert property (@(posedge clk) disable iff (!arst_n)
		in_xfer && (s_axis_tuser == CMD_INSERT || s_axis_tuser == CMD_CLEAR) |=>
			m_axis_tvalid && !m_axis_tuser && (m_axis_tdata == '0))
		else $error("insert or clear result not empty");

	a_result_source: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(m_axis_tvalid) |-> $past(in_xfer) || !$past(s_axis_tready))
		else $error("result without a transaction");

endmodule

bind page_translation_fifo_cache ptfc_checker u_ptfc_checker (
	.clk           (clk),
	.arst_n        (arst_n),
	.s_axis_tvalid (s_axis_tvalid),
	.s_axis_tready (s_axis_tready),
	.s_axis_tuser  (s_axis_tuser),
	.m_axis_tvalid (m_axis_tvalid),
	.m_axis_tready (m_axis_tready),
	.m_axis_tdata  (m_axis_tdata),
	.m_axis_tuser  (m_axis_tuser)
);
